### design/lcdseq_pkg.sv
`timescale 1ns / 1ps
package lcdseq_pkg;

  localparam int MAX_DIGITS_DEF = 10;
  localparam int FIFO_DEPTH_DEF = 4;
  localparam int NUM_BITS       = 32;

  // request codes
  localparam logic [2:0] REQ_INIT  = 3'd0;
  localparam logic [2:0] REQ_CMD   = 3'd1;
  localparam logic [2:0] REQ_DATA  = 3'd2;
  localparam logic [2:0] REQ_CLEAR = 3'd3;
  localparam logic [2:0] REQ_GOTO  = 3'd4;
  localparam logic [2:0] REQ_INT   = 3'd5;

  // register indexes
  localparam logic [1:0] CFG_FUNCTION_SET  = 2'd0;
  localparam logic [1:0] CFG_DISPLAY_CTRL  = 2'd1;
  localparam logic [1:0] CFG_ENTRY_MODE    = 2'd2;

  localparam logic [7:0] FUNCTION_SET_RST  = 8'h28;
  localparam logic [7:0] DISPLAY_CTRL_RST  = 8'h0C;
  localparam logic [7:0] ENTRY_MODE_RST    = 8'h06;

  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_MINUS    = 8'h2D;
  localparam logic [3:0] WAKE_NIBBLE   = 4'h3;
  localparam logic [3:0] MODE4_NIBBLE  = 4'h2;

  localparam logic [2:0] INIT_LAST_STEP = 3'd6;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [7:0]         byte_value;
    logic [4:0]         column;
    logic [1:0]         row;
    logic signed [31:0] number;
  } req_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       strobe_res;
    logic       extra_wait_ms;
    logic       last;
  } xfer_t;

  // one queue entry: a whole byte (two strobed nibbles) or one raw nibble
  typedef struct packed {
    logic       is_byte;
    logic       rs;
    logic [7:0] value;
    logic       strobe;
    logic       wait_ms;
    logic       last;
  } entry_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_INIT,
    F_BYTE,
    F_CONV,
    F_SKIP,
    F_SIGN,
    F_DIGIT
  } front_state_t;

  function automatic logic [7:0] line_base(input logic [1:0] row);
    case (row)
      2'd0:    line_base = 8'h00;
      2'd1:    line_base = 8'h40;
      2'd2:    line_base = 8'h14;
      default: line_base = 8'h54;
    endcase
  endfunction

  function automatic entry_t byte_entry(input logic rs, input logic [7:0] value,
                                        input logic wait_ms, input logic last);
    entry_t e;
    e.is_byte = 1'b1;
    e.rs      = rs;
    e.value   = value;
    e.strobe  = 1'b1;
    e.wait_ms = wait_ms;
    e.last    = last;
    return e;
  endfunction

  function automatic entry_t nibble_entry(input logic [3:0] nib, input logic strobe);
    entry_t e;
    e.is_byte = 1'b0;
    e.rs      = 1'b0;
    e.value   = {4'h0, nib};
    e.strobe  = strobe;
    e.wait_ms = 1'b1;
    e.last    = 1'b0;
    return e;
  endfunction

  // power-up sequence, one entry per step
  function automatic entry_t init_entry(input logic [2:0] step, input logic [7:0] fs,
                                        input logic [7:0] dc, input logic [7:0] em);
    case (step)
      3'd0:    init_entry = nibble_entry(4'h0, 1'b0);
      3'd1:    init_entry = nibble_entry(WAKE_NIBBLE, 1'b1);
      3'd2:    init_entry = nibble_entry(MODE4_NIBBLE, 1'b1);
      3'd3:    init_entry = byte_entry(1'b0, fs, 1'b0, 1'b0);
      3'd4:    init_entry = byte_entry(1'b0, dc, 1'b0, 1'b0);
      3'd5:    init_entry = byte_entry(1'b0, CMD_CLEAR, 1'b1, 1'b0);
      default: init_entry = byte_entry(1'b0, em, 1'b0, 1'b1);
    endcase
  endfunction

endpackage

### design/lcdseq_chan_if.sv
`timescale 1ns / 1ps
interface lcdseq_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### design/char_lcd_nibble_write_sequencer.sv
`timescale 1ns / 1ps
// Character LCD 4-bit bus sequencer.
// req (sink): one request per item: init, command byte, data byte, clear,
//   cursor goto or a signed integer printed in decimal. Types 6 and 7 are
//   taken and dropped.
// xfer (source): one item per bus transfer, high nibble first, with RS,
//   the nibble, a strobe flag, an extra millisecond wait flag and a last flag.
// cfg_we/cfg_index/cfg_data: write the init command bytes (function set,
//   display control, entry mode); write only while no request is in flight.
// The front end takes a new request only when it has queued every byte of
// the previous one. Integers go through the bit-serial binary to BCD
// converter, then their leading zeros are dropped (at least one digit
// stays), then their characters are queued, a minus sign first if negative.
// The back end sends one nibble per cycle while it has entries to send and
// xfer is not stalled; a byte request passes through the queue and the
// back end's current-entry register before its first transfer appears.
// A 4-entry queue lets the front run ahead while xfer is stalled; a stalled
// transfer holds its value. Reset empties the queue and restores the three
// command registers to 0x28, 0x0C and 0x06.
module char_lcd_nibble_write_sequencer #(
  parameter int MAX_DIGITS = lcdseq_pkg::MAX_DIGITS_DEF,
  parameter int FIFO_DEPTH = lcdseq_pkg::FIFO_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  lcdseq_chan_if.sink   req,
  lcdseq_chan_if.source xfer
);
  import lcdseq_pkg::*;

  logic   push;
  entry_t push_data;
  logic   fifo_full;
  logic   pop;
  entry_t pop_data;
  logic   fifo_valid;
  req_t   req_data;
  xfer_t  out_data;

  assign req_data     = req.payload;
  assign xfer.payload = out_data;

  lcdseq_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_data  (req_data),
    .push      (push),
    .push_data (push_data),
    .fifo_full (fifo_full)
  );

  lcdseq_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (fifo_valid)
  );

  lcdseq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_valid (fifo_valid),
    .fifo_data  (pop_data),
    .pop        (pop),
    .out_valid  (xfer.valid),
    .out_ready  (xfer.ready),
    .out_data   (out_data)
  );

endmodule

### design/lcdseq_front.sv
`timescale 1ns / 1ps
module lcdseq_front #(
  parameter int MAX_DIGITS = lcdseq_pkg::MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               req_valid,
  output logic               req_ready,
  input  lcdseq_pkg::req_t   req_data,
  output logic               push,
  output lcdseq_pkg::entry_t push_data,
  input  logic               fifo_full
);
  import lcdseq_pkg::*;

  localparam int BCD_W = 4 * MAX_DIGITS;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int BIT_W = $clog2(NUM_BITS);

  front_state_t state, state_next;

  logic [7:0]          function_set;
  logic [7:0]          display_ctrl;
  logic [7:0]          entry_mode;
  logic [2:0]          step;
  entry_t              pend;
  logic [NUM_BITS-1:0] mag;
  logic                neg;
  logic [BCD_W-1:0]    bcd;
  logic [BCD_W-1:0]    bcd_adj;
  logic [BIT_W-1:0]    bit_cnt;
  logic [CNT_W-1:0]    dig_cnt;
  logic [3:0]          top_digit;
  logic                take;
  logic [7:0]          goto_addr;

  assign take      = req_valid && req_ready;
  assign top_digit = bcd[BCD_W-1 -: 4];
  assign goto_addr = line_base(req_data.row) + {3'b000, req_data.column};

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (req_valid) begin
          case (req_data.req_type)
            REQ_INIT:  state_next = F_INIT;
            REQ_CMD:   state_next = F_BYTE;
            REQ_DATA:  state_next = F_BYTE;
            REQ_CLEAR: state_next = F_BYTE;
            REQ_GOTO:  state_next = F_BYTE;
            REQ_INT:   state_next = F_CONV;
            default:   state_next = F_IDLE;
          endcase
        end
      end
      F_INIT: begin
        if (!fifo_full && step == INIT_LAST_STEP) state_next = F_IDLE;
      end
      F_BYTE: begin
        if (!fifo_full) state_next = F_IDLE;
      end
      F_CONV: begin
        if (bit_cnt == BIT_W'(NUM_BITS - 1)) state_next = F_SKIP;
      end
      F_SKIP: begin
        if (!(top_digit == 4'd0 && dig_cnt > CNT_W'(1))) state_next = neg ? F_SIGN : F_DIGIT;
      end
      F_SIGN: begin
        if (!fifo_full) state_next = F_DIGIT;
      end
      F_DIGIT: begin
        if (!fifo_full && dig_cnt == CNT_W'(1)) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    push      = 1'b0;
    push_data = pend;
    case (state)
      F_IDLE: req_ready = 1'b1;
      F_INIT: begin
        push      = !fifo_full;
        push_data = init_entry(step, function_set, display_ctrl, entry_mode);
      end
      F_BYTE: push = !fifo_full;
      F_SIGN: begin
        push      = !fifo_full;
        push_data = byte_entry(1'b1, CHAR_MINUS, 1'b0, 1'b0);
      end
      F_DIGIT: begin
        push      = !fifo_full;
        push_data = byte_entry(1'b1, CHAR_ZERO | {4'h0, top_digit}, 1'b0,
                               dig_cnt == CNT_W'(1));
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      function_set <= FUNCTION_SET_RST;
      display_ctrl <= DISPLAY_CTRL_RST;
      entry_mode   <= ENTRY_MODE_RST;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FUNCTION_SET: function_set <= cfg_data;
          CFG_DISPLAY_CTRL: display_ctrl <= cfg_data;
          CFG_ENTRY_MODE:   entry_mode   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      step    <= 3'd0;
      bit_cnt <= '0;
      bcd     <= '0;
      dig_cnt <= CNT_W'(MAX_DIGITS);
      neg     <= req_data.number[NUM_BITS-1];
      mag     <= req_data.number[NUM_BITS-1] ? NUM_BITS'(-req_data.number)
                                              : req_data.number;
      case (req_data.req_type)
        REQ_DATA:  pend <= byte_entry(1'b1, req_data.byte_value, 1'b0, 1'b1);
        REQ_CLEAR: pend <= byte_entry(1'b0, CMD_CLEAR, 1'b1, 1'b1);
        REQ_GOTO:  pend <= byte_entry(1'b0, CMD_SET_DDRAM | goto_addr, 1'b0, 1'b1);
        default:   pend <= byte_entry(1'b0, req_data.byte_value, 1'b0, 1'b1);
      endcase
    end else begin
      case (state)
        F_INIT: if (!fifo_full) step <= step + 3'd1;
        F_CONV: begin
          bcd     <= {bcd_adj[BCD_W-2:0], mag[NUM_BITS-1]};
          mag     <= {mag[NUM_BITS-2:0], 1'b0};
          bit_cnt <= bit_cnt + BIT_W'(1);
        end
        F_SKIP: begin
          // drop leading zeros, keep at least one digit
          if (top_digit == 4'd0 && dig_cnt > CNT_W'(1)) begin
            bcd     <= {bcd[BCD_W-5:0], 4'h0};
            dig_cnt <= dig_cnt - CNT_W'(1);
          end
        end
        F_DIGIT: begin
          if (!fifo_full) begin
            bcd     <= {bcd[BCD_W-5:0], 4'h0};
            dig_cnt <= dig_cnt - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### design/lcdseq_fifo.sv
`timescale 1ns / 1ps
module lcdseq_fifo #(
  parameter int DEPTH = lcdseq_pkg::FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lcdseq_pkg::entry_t push_data,
  output logic               full,
  input  logic               pop,
  output lcdseq_pkg::entry_t pop_data,
  output logic               not_empty
);
  import lcdseq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = count == CNT_W'(DEPTH);
  assign not_empty = count != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop) count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

endmodule

### design/lcdseq_back.sv
`timescale 1ns / 1ps
module lcdseq_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               fifo_valid,
  input  lcdseq_pkg::entry_t fifo_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output lcdseq_pkg::xfer_t  out_data
);
  import lcdseq_pkg::*;

  entry_t cur;
  logic   cur_valid;
  logic   phase;
  logic   load;
  logic   adv;
  logic   done;
  xfer_t  nxt;

  assign load = !out_valid || out_ready;
  assign adv  = load && cur_valid;
  // a byte finishes on its low nibble, a raw nibble at once
  assign done = adv && (!cur.is_byte || phase);
  assign pop  = fifo_valid && (!cur_valid || done);

  always_comb begin
    nxt.reg_select    = cur.rs;
    nxt.nibble        = (cur.is_byte && !phase) ? cur.value[7:4] : cur.value[3:0];
    nxt.strobe_res    = cur.is_byte || cur.strobe;
    nxt.extra_wait_ms = cur.is_byte ? (phase && cur.wait_ms) : cur.wait_ms;
    nxt.last          = cur.last && (!cur.is_byte || phase);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        phase     <= 1'b0;
      end else if (done) begin
        cur_valid <= 1'b0;
      end else if (adv) begin
        phase <= 1'b1;
      end
      if (load) out_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= fifo_data;
    if (adv) out_data <= nxt;
  end

endmodule
